>>> rtl/esds_asc_locator_defines.svh
// Assertion macros of the descriptor locator RTL, used by the walker.
// Include with the bare file name inside a module body.
`ifndef ESDS_ASC_LOCATOR_DEFINES_SVH
`define ESDS_ASC_LOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/esds_pkg.sv
// Shared types and constants of the descriptor locator.
// Used by the interfaces, the walker, the output stage and the top level.
`default_nettype none

package esds_pkg;

  localparam int LenW = 16;
  localparam int AccW = 28;
  localparam int ByteW = 8;

  localparam logic [ByteW-1:0] TagEs = 8'h03;
  localparam logic [ByteW-1:0] TagDecConfig = 8'h04;
  localparam logic [ByteW-1:0] TagDecSpecific = 8'h05;

  localparam int MoreBit = 7;
  localparam int FlagDep = 7;
  localparam int FlagUrl = 6;
  localparam int FlagOcr = 5;

  localparam logic [1:0] LenCntMax = 2'd3;
  localparam logic [LenW-1:0] EsFixedSkip = LenW'(3);
  localparam logic [LenW-1:0] ConfigSkip = LenW'(13);
  localparam logic [LenW-1:0] OptSkip = LenW'(2);
  localparam logic [LenW-1:0] MinBlobLen = LenW'(6);

  typedef enum logic [9:0] {
    PhFirstTag = 10'b00_0000_0001,
    PhFirstLen = 10'b00_0000_0010,
    PhTag      = 10'b00_0000_0100,
    PhLen      = 10'b00_0000_1000,
    PhSkip     = 10'b00_0001_0000,
    PhEsFixed  = 10'b00_0010_0000,
    PhEsDep    = 10'b00_0100_0000,
    PhEsUrlLen = 10'b00_1000_0000,
    PhEsUrl    = 10'b01_0000_0000,
    PhDone     = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    StgDep    = 2'd0,
    StgUrlLen = 2'd1,
    StgOcr    = 2'd2
  } es_stage_e;

  typedef struct packed {
    logic            trimmed;
    logic [LenW-1:0] payload_offset;
    logic [LenW-1:0] new_length;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/esds_byte_if.sv
// Valid/ready channel that carries one blob byte per word.
// Depends on esds_pkg for the field widths.
`default_nettype none

interface esds_byte_if;
  import esds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ByteW-1:0]       data_byte;
  logic [LenW-1:0]        blob_length;
  logic                   last_byte;

  modport source (output valid, output data_byte, output blob_length, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input blob_length, input last_byte,
                output ready);
endinterface

`default_nettype wire

>>> rtl/esds_result_if.sv
// Valid/ready channel that carries one locator result per word.
// Depends on esds_pkg for the field widths.
`default_nettype none

interface esds_result_if;
  import esds_pkg::*;

  logic            valid;
  logic            ready;
  logic            trimmed;
  logic [LenW-1:0] payload_offset;
  logic [LenW-1:0] new_length;

  modport source (output valid, output trimmed, output payload_offset, output new_length,
                  input ready);
  modport sink (input valid, input trimmed, input payload_offset, input new_length,
                output ready);
endinterface

`default_nettype wire

>>> rtl/esds_asc_locator.sv
// Top level of the streaming descriptor locator.
// Depends on esds_pkg, esds_byte_if, esds_result_if, esds_walker and esds_out_stage.
//
// The block takes an audio configuration blob on byte_i, one byte per word,
// each word also carrying the blob length and a flag on the final byte. It
// walks the descriptor chain on the fly and stores no data bytes. On the
// word with the final-byte flag it emits one word on result_o: either the
// payload offset and length of the decoder-specific descriptor, or the
// unchanged blob length.
// A byte is taken in every cycle while the result register is empty or is
// being read; the result is registered and appears in the cycle after the
// final byte is taken. Throughput is one byte per cycle while byte_i.ready
// is high. When result_o is stalled with a word pending, byte_i.ready drops
// until that word is taken. Reset clears the walk state and empties the
// result register; the block is ready as soon as reset is released.
`default_nettype none

module esds_asc_locator (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  esds_byte_if.sink     byte_i,
  esds_result_if.source result_o
);
  import esds_pkg::*;

  logic accept;
  logic res_valid;
  res_t res;
  logic stage_ready;

  assign byte_i.ready = stage_ready;
  assign accept = byte_i.valid && stage_ready;

  esds_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (byte_i.data_byte),
    .blob_length_i (byte_i.blob_length),
    .last_byte_i   (byte_i.last_byte),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  esds_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (stage_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

>>> rtl/esds_walker.sv
// Descriptor walk state: updates the parse state on every accepted byte and
// forms the result on the final byte. Depends on esds_pkg and the defines header.
`default_nettype none

module esds_walker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [esds_pkg::ByteW-1:0] data_byte_i,
  input  wire logic [esds_pkg::LenW-1:0]  blob_length_i,
  input  wire logic                      last_byte_i,
  output logic                           res_valid_o,
  output esds_pkg::res_t                 res_o
);
  import esds_pkg::*;
  `include "esds_asc_locator_defines.svh"

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [ByteW-1:0] tag_q, tag_d;
  logic [LenW-1:0]  skip_q, skip_d;
  logic [ByteW-1:0] flags_q, flags_d;
  logic             failed_q, failed_d;
  logic             found_q, found_d;
  logic [LenW-1:0]  off_q, off_d;
  logic [LenW-1:0]  flen_q, flen_d;

  logic             take;
  logic [AccW-1:0]  acc_new;
  logic [LenW-1:0]  body;
  logic [LenW-1:0]  rem;
  logic             too_long;
  logic             first;

  function automatic phase_e es_next(es_stage_e stage, logic [ByteW-1:0] flags);
    phase_e ph;
    if (stage == StgDep && flags[FlagDep]) begin
      ph = PhEsDep;
    end else if ((stage == StgDep || stage == StgUrlLen) && flags[FlagUrl]) begin
      ph = PhEsUrlLen;
    end else if (flags[FlagOcr]) begin
      ph = PhSkip;
    end else begin
      ph = PhTag;
    end
    return ph;
  endfunction

  assign take = accept_i && (pos_q < blob_length_i) && (phase_q != PhDone);
  assign acc_new = {acc_q[AccW-8:0], data_byte_i[6:0]};
  assign body = pos_q + LenW'(1);
  assign rem = blob_length_i - body;
  assign too_long = (|acc_new[AccW-1:LenW]) || (acc_new[LenW-1:0] > rem);
  assign first = (phase_q == PhFirstLen);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    tag_d    = tag_q;
    skip_d   = skip_q;
    flags_d  = flags_q;
    failed_d = failed_q;
    found_d  = found_q;
    off_d    = off_q;
    flen_d   = flen_q;

    if (take) begin
      unique case (phase_q)
        PhFirstTag, PhTag: begin
          if (phase_q == PhFirstTag && data_byte_i != TagEs) begin
            failed_d = 1'b1;
            phase_d  = PhDone;
          end else begin
            tag_d   = data_byte_i;
            acc_d   = '0;
            cnt_d   = '0;
            phase_d = (phase_q == PhFirstTag) ? PhFirstLen : PhLen;
          end
        end
        PhFirstLen, PhLen: begin
          acc_d = acc_new;
          if (data_byte_i[MoreBit] && cnt_q != LenCntMax) begin
            cnt_d = cnt_q + 2'd1;
          end else if (too_long || (first && acc_new == '0)) begin
            failed_d = 1'b1;
            phase_d  = PhDone;
          end else if (tag_q == TagDecSpecific) begin
            found_d = 1'b1;
            off_d   = body;
            flen_d  = acc_new[LenW-1:0];
            phase_d = PhDone;
          end else if (tag_q == TagEs) begin
            skip_d  = EsFixedSkip;
            phase_d = PhEsFixed;
          end else if (tag_q == TagDecConfig) begin
            skip_d  = ConfigSkip;
            phase_d = PhSkip;
          end else if (acc_new == '0) begin
            phase_d = PhTag;
          end else begin
            skip_d  = acc_new[LenW-1:0];
            phase_d = PhSkip;
          end
        end
        PhSkip: begin
          skip_d = skip_q - LenW'(1);
          if (skip_q == LenW'(1)) begin
            phase_d = PhTag;
          end
        end
        PhEsFixed: begin
          skip_d = skip_q - LenW'(1);
          if (skip_q == LenW'(1)) begin
            flags_d = data_byte_i;
            skip_d  = OptSkip;
            phase_d = es_next(StgDep, data_byte_i);
          end
        end
        PhEsDep: begin
          skip_d = skip_q - LenW'(1);
          if (skip_q == LenW'(1)) begin
            skip_d  = OptSkip;
            phase_d = es_next(StgUrlLen, flags_q);
          end
        end
        PhEsUrlLen: begin
          if (data_byte_i == '0) begin
            skip_d  = OptSkip;
            phase_d = es_next(StgOcr, flags_q);
          end else begin
            skip_d  = LenW'(data_byte_i);
            phase_d = PhEsUrl;
          end
        end
        PhEsUrl: begin
          skip_d = skip_q - LenW'(1);
          if (skip_q == LenW'(1)) begin
            skip_d  = OptSkip;
            phase_d = es_next(StgOcr, flags_q);
          end
        end
        PhDone: begin
        end
        default: begin
        end
      endcase
    end

    if (accept_i && pos_q != '1) begin
      pos_d = pos_q + LenW'(1);
    end

    res_valid_o = accept_i && last_byte_i;
    res_o.trimmed = found_d && !failed_d && (blob_length_i >= MinBlobLen) && (flen_d != '0);
    res_o.payload_offset = res_o.trimmed ? off_d : '0;
    res_o.new_length = res_o.trimmed ? flen_d : blob_length_i;

    if (accept_i && last_byte_i) begin
      phase_d  = PhFirstTag;
      pos_d    = '0;
      acc_d    = '0;
      cnt_d    = '0;
      tag_d    = '0;
      skip_d   = '0;
      flags_d  = '0;
      failed_d = 1'b0;
      found_d  = 1'b0;
      off_d    = '0;
      flen_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirstTag;
      pos_q    <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      tag_q    <= '0;
      skip_q   <= '0;
      flags_q  <= '0;
      failed_q <= 1'b0;
      found_q  <= 1'b0;
      off_q    <= '0;
      flen_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      tag_q    <= tag_d;
      skip_q   <= skip_d;
      flags_q  <= flags_d;
      failed_q <= failed_d;
      found_q  <= found_d;
      off_q    <= off_d;
      flen_q   <= flen_d;
    end
  end

  `ESDS_ASSERT_IMPLY(a_found_fail_excl, clk_i, rst_ni, found_q, !failed_q, "payload found after failure")
  `ESDS_ASSERT_IMPLY(a_end_in_done, clk_i, rst_ni, found_q || failed_q, phase_q == PhDone, "walk ended outside done phase")
  `ESDS_ASSERT_NEXT(a_last_resets, clk_i, rst_ni, accept_i && last_byte_i, phase_q == PhFirstTag && pos_q == '0 && !found_q, "state not cleared after final word")

endmodule

`default_nettype wire

>>> rtl/esds_out_stage.sv
// Result register between the walker and the result channel.
// Depends on esds_pkg and esds_result_if.
`default_nettype none

module esds_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           res_valid_i,
  input  wire esds_pkg::res_t res_i,
  output logic                ready_o,
  esds_result_if.source       result_o
);
  import esds_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign ready_o = !vld_q || result_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (res_valid_i) begin
      vld_d = 1'b1;
    end else if (result_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid          = vld_q;
  assign result_o.trimmed        = res_q.trimmed;
  assign result_o.payload_offset = res_q.payload_offset;
  assign result_o.new_length     = res_q.new_length;

endmodule

`default_nettype wire

>>> test/esds_asc_locator_tb.sv
// Self-checking testbench for the esds_asc_locator descriptor walker.
// Depends on esds_pkg, esds_byte_if, esds_result_if and the esds_asc_locator RTL.
// A directed table runs first, then random chains checked by a bit-true walk predictor.
`default_nettype none

module esds_asc_locator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esds_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  blen;
    logic             last;
    logic [31:0]      reps;
    logic             pinned;
    res_t             want;
  } row_t;

  localparam int unsigned RandItems = 1325;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [ByteW-1:0] OcrOnly = ByteW'(1 << FlagOcr);

  localparam int NumRows = 25;
  localparam row_t DirRows [NumRows] = '{
    '{8'h00, 16'h0000, 1'b1, 32'd1, 1'b1, '{1'b0, 16'h0000, 16'h0000}},
    '{8'hff, 16'hffff, 1'b1, 32'd1, 1'b1, '{1'b0, 16'h0000, 16'hffff}},
    '{TagEs, 16'h0006, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h00, 16'h0006, 1'b1, 32'd1, 1'b1, '{1'b0, 16'h0000, 16'h0006}},
    '{TagEs, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h00, 16'h0000, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h07, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h00, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h01, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h00, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{TagDecSpecific, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h02, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'haa, 16'hffff, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'hbb, 16'hffff, 1'b1, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{TagEs, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h09, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h00, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h01, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{OcrOnly, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h11, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h22, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{TagDecSpecific, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h02, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'haa, 16'h000b, 1'b0, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
    '{8'h55, 16'h000b, 1'b1, 32'd1, 1'b0, '{1'b0, 16'h0000, 16'h0000}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  esds_byte_if   byte_ch ();
  esds_result_if res_ch ();

  esds_asc_locator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .byte_i  (byte_ch),
    .result_o(res_ch)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  phase_e           walk_phase;
  logic [LenW-1:0]  walk_pos;
  logic [AccW-1:0]  len_acc;
  logic [1:0]       len_cnt;
  logic [ByteW-1:0] cur_tag;
  logic [LenW-1:0]  skip_cnt;
  logic [ByteW-1:0] es_flags;
  logic             walk_failed;
  logic             asc_found;
  logic [LenW-1:0]  asc_offset;
  logic [LenW-1:0]  asc_length;

  res_t             pending_results[$];
  logic [ByteW-1:0] blob_q[$];
  int unsigned      mismatch_cnt = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      bytes_sent = 0;
  bit               src_idle = 1'b0;
  bit               snk_idle = 1'b0;
  bit               hold_req = 1'b0;
  bit               pin_on = 1'b0;
  res_t             pin_res = '0;

  task automatic walk_clear();
    walk_pos = '0;
    walk_phase = PhFirstTag;
    len_acc = '0;
    len_cnt = '0;
    cur_tag = '0;
    skip_cnt = '0;
    es_flags = '0;
    walk_failed = 1'b0;
    asc_found = 1'b0;
    asc_offset = '0;
    asc_length = '0;
  endtask

  task automatic walk_fail();
    walk_failed = 1'b1;
    walk_phase = PhDone;
  endtask

  task automatic es_enter(input es_stage_e stg);
    if (stg == StgDep && es_flags[FlagDep]) begin
      skip_cnt = OptSkip;
      walk_phase = PhEsDep;
    end else if (stg != StgOcr && es_flags[FlagUrl]) begin
      walk_phase = PhEsUrlLen;
    end else if (es_flags[FlagOcr]) begin
      skip_cnt = OptSkip;
      walk_phase = PhSkip;
    end else begin
      walk_phase = PhTag;
    end
  endtask

  task automatic header_close(input logic [LenW:0] body, input logic [LenW-1:0] n,
                              input bit first);
    logic [LenW:0] rem;
    rem = {1'b0, n} - body;
    if (len_acc > {{(AccW-LenW-1){1'b0}}, rem} || (first && len_acc == '0)) begin
      walk_fail();
    end else if (cur_tag == TagDecSpecific) begin
      asc_found = 1'b1;
      asc_offset = body[LenW-1:0];
      asc_length = len_acc[LenW-1:0];
      walk_phase = PhDone;
    end else if (cur_tag == TagEs) begin
      skip_cnt = EsFixedSkip;
      walk_phase = PhEsFixed;
    end else if (cur_tag == TagDecConfig) begin
      skip_cnt = ConfigSkip;
      walk_phase = PhSkip;
    end else if (len_acc == '0) begin
      walk_phase = PhTag;
    end else begin
      skip_cnt = len_acc[LenW-1:0];
      walk_phase = PhSkip;
    end
  endtask

  task automatic walk_byte(input logic [ByteW-1:0] b, input logic [LenW-1:0] pos,
                           input logic [LenW-1:0] n);
    case (walk_phase)
      PhFirstTag, PhTag: begin
        if (walk_phase == PhFirstTag && b != TagEs) begin
          walk_fail();
        end else begin
          cur_tag = b;
          len_acc = '0;
          len_cnt = '0;
          walk_phase = (walk_phase == PhFirstTag) ? PhFirstLen : PhLen;
        end
      end
      PhFirstLen, PhLen: begin
        len_acc = {len_acc[AccW-8:0], b[6:0]};
        if (b[MoreBit] && len_cnt < LenCntMax) begin
          len_cnt = len_cnt + 2'd1;
        end else begin
          header_close({1'b0, pos} + 1'b1, n, walk_phase == PhFirstLen);
        end
      end
      PhSkip: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == '0) walk_phase = PhTag;
      end
      PhEsFixed: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == '0) begin
          es_flags = b;
          es_enter(StgDep);
        end
      end
      PhEsDep: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == '0) es_enter(StgUrlLen);
      end
      PhEsUrlLen: begin
        if (b == '0) begin
          es_enter(StgOcr);
        end else begin
          skip_cnt = LenW'(b);
          walk_phase = PhEsUrl;
        end
      end
      PhEsUrl: begin
        skip_cnt = skip_cnt - 1'b1;
        if (skip_cnt == '0) es_enter(StgOcr);
      end
      default: ;
    endcase
  endtask

  task automatic locate_step(input logic [ByteW-1:0] b, input logic [LenW-1:0] n,
                             input logic last, output bit got, output res_t res);
    got = last;
    res = '0;
    if (walk_pos < n && walk_phase != PhDone) walk_byte(b, walk_pos, n);
    if (walk_pos != '1) walk_pos = walk_pos + 1'b1;
    if (last) begin
      if (asc_found && !walk_failed && n >= MinBlobLen && asc_length != '0) begin
        res = {1'b1, asc_offset, asc_length};
      end else begin
        res = {1'b0, {LenW{1'b0}}, n};
      end
      walk_clear();
    end
  endtask

  task automatic check_field(input string name, input logic [LenW-1:0] want,
                             input logic [LenW-1:0] seen);
    if (seen !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin : score
    bit   got;
    res_t want;
    if (rst_n) begin
      if (byte_ch.valid && byte_ch.ready) begin
        locate_step(byte_ch.data_byte, byte_ch.blob_length, byte_ch.last_byte, got, want);
        if (got) begin
          if (pin_on) want = pin_res;
          pending_results.push_back(want);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected word, expected none, got trimmed=%0d offset=0x%0h %s0x%0h",
                   $time, res_ch.trimmed, res_ch.payload_offset, "len=", res_ch.new_length);
        end else begin
          want = pending_results.pop_front();
          check_field("trimmed", LenW'(want.trimmed), LenW'(res_ch.trimmed));
          check_field("payload_offset", want.payload_offset, res_ch.payload_offset);
          check_field("new_length", want.new_length, res_ch.new_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [ByteW-1:0] b, input logic [LenW-1:0] n,
                           input logic last);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= b;
    byte_ch.blob_length <= n;
    byte_ch.last_byte   <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] len_byte(input int unsigned v, input int unsigned nb,
                                                input int unsigned k);
    logic [ByteW-1:0] b;
    b = ByteW'(v >> (7 * (nb - 1 - k))) & 8'h7f;
    if (k < nb - 1) b[MoreBit] = 1'b1;
    return b;
  endfunction

  task automatic build_chain();
    int unsigned      es_at, es_nb, cfg_at, cfg_nb, nb, u, v, k;
    logic [ByteW-1:0] flags, tag;
    bit               has_cfg;
    blob_q.delete();
    blob_q.push_back(TagEs);
    es_at = blob_q.size();
    es_nb = $urandom_range(1, 4);
    repeat (es_nb) blob_q.push_back(8'h00);
    repeat (2) blob_q.push_back(ByteW'($urandom));
    flags = ByteW'($urandom);
    blob_q.push_back(flags);
    if (flags[FlagDep]) repeat (2) blob_q.push_back(ByteW'($urandom));
    if (flags[FlagUrl]) begin
      u = ($urandom_range(0, 31) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      blob_q.push_back(ByteW'(u));
      repeat (u) blob_q.push_back(ByteW'($urandom));
    end
    if (flags[FlagOcr]) repeat (2) blob_q.push_back(ByteW'($urandom));
    has_cfg = ($urandom_range(0, 3) != 0);
    cfg_at = 0;
    cfg_nb = 1;
    if (has_cfg) begin
      blob_q.push_back(TagDecConfig);
      cfg_at = blob_q.size();
      cfg_nb = $urandom_range(1, 4);
      repeat (cfg_nb) blob_q.push_back(8'h00);
      repeat (13) blob_q.push_back(ByteW'($urandom));
    end
    repeat ($urandom_range(0, 2)) begin
      tag = ByteW'($urandom);
      if (tag inside {TagEs, TagDecConfig, TagDecSpecific}) tag = 8'h06;
      v = $urandom_range(0, 4);
      nb = $urandom_range(1, 2);
      blob_q.push_back(tag);
      for (k = 0; k < nb; k++) blob_q.push_back(len_byte(v, nb, k));
      repeat (v) blob_q.push_back(ByteW'($urandom));
    end
    blob_q.push_back(TagDecSpecific);
    v = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    nb = $urandom_range(1, 4);
    for (k = 0; k < nb; k++) blob_q.push_back(len_byte(v, nb, k));
    repeat (v) blob_q.push_back(ByteW'($urandom));
    repeat ($urandom_range(0, 3)) blob_q.push_back(ByteW'($urandom));
    v = blob_q.size() - es_at - es_nb;
    if ($urandom_range(0, 7) == 0) v = v + $urandom_range(0, 2);
    for (k = 0; k < es_nb; k++) blob_q[es_at + k] = len_byte(v, es_nb, k);
    if (es_nb == 4 && $urandom_range(0, 3) == 0) blob_q[es_at + 3][MoreBit] = 1'b1;
    if (has_cfg) begin
      v = blob_q.size() - cfg_at - cfg_nb;
      for (k = 0; k < cfg_nb; k++) blob_q[cfg_at + k] = len_byte(v, cfg_nb, k);
    end
  endtask

  task automatic send_blob();
    int unsigned     nlen, cnt, i;
    bit              jitter;
    logic [LenW-1:0] n;
    if ($urandom_range(0, 9) == 0) begin
      blob_q.delete();
      repeat ($urandom_range(1, 10)) blob_q.push_back(ByteW'($urandom));
      if ($urandom_range(0, 1) == 1) blob_q[0] = TagEs;
    end else begin
      build_chain();
    end
    nlen = blob_q.size();
    cnt = blob_q.size();
    jitter = 1'b0;
    case ($urandom_range(0, 11))
      0: blob_q[$urandom_range(0, blob_q.size() - 1)] = ByteW'($urandom);
      1: cnt = $urandom_range(1, blob_q.size());
      2: begin
        repeat ($urandom_range(1, 4)) blob_q.push_back(ByteW'($urandom));
        cnt = blob_q.size();
      end
      3: nlen = $urandom_range(0, nlen + 3);
      4: nlen = $urandom_range(0, 65535);
      5: jitter = 1'b1;
      default: ;
    endcase
    for (i = 0; i < cnt; i++) begin
      n = LenW'(nlen);
      if (jitter && $urandom_range(0, 3) == 0) n = LenW'($urandom_range(0, nlen + 2));
      send_word(blob_q[i], n, i == cnt - 1);
    end
    bytes_sent += cnt;
  endtask

  initial begin : main
    bit   hold_done;
    row_t row;
    int   r;
    hold_done = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.blob_length = '0;
    byte_ch.last_byte = 1'b0;
    walk_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snk_idle = 1'b1;
    for (r = 0; r < NumRows; r++) begin
      row = DirRows[r];
      src_idle = (row.reps == 1);
      pin_on = row.pinned;
      pin_res = row.want;
      repeat (row.reps) send_word(row.data, row.blen, row.last);
    end
    pin_on = 1'b0;

    while (bytes_sent < RandItems) begin
      if (bytes_sent >= RandItems * 4 / 5) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end else begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      if (!hold_done && bytes_sent >= RandItems / 2) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      send_blob();
    end
    byte_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
